// ===== rtl/core/mpr_pkg.sv =====
// shared constants for the masked pixel to rgb888 core
// no dependencies; used by every module of the core
package mpr_pkg;

    localparam int MASK_W         = 32;
    localparam int OUT_W          = 8;
    localparam int CHANNELS       = 3;
    localparam int PIXEL_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int DIV_STEPS      = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;

    // channel slots
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // cycles that the derived mask values need after a register write
    localparam logic [1:0] CFG_SETTLE = 2'd3;

endpackage

// ===== rtl/core/masked_pixel_to_rgb888_core.sv =====
// top level of the masked pixel to rgb888 converter
// depends on mpr_pkg, mpr_cfg, mpr_front, mpr_div_stage
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: pixel_word
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: red_out, green_out, blue_out
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (mask value)
//
// one pixel per cycle unless m_tready stalls or a mask write holds s_tready low;
// two front stages (mask/align, times-255 product) and eight restoring divide
// stages, one quotient bit each; every stage has its own valid bit and ready,
// so bubbles close up under stall; after reset and after each mask write
// s_tready stays low while the shift count and divisor of each mask are derived
module masked_pixel_to_rgb888_core #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF,
    localparam int IN_W = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // pixel_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [3*mpr_pkg::OUT_W-1:0]   m_tdata,   // red_out, green_out, blue_out
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpr_pkg::MASK_W-1:0]    cfg_data
);

    localparam int TZW = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
    localparam int NW  = PIXEL_BITS + mpr_pkg::OUT_W;
    localparam int NS  = mpr_pkg::DIV_STEPS;

    logic                         busy;
    logic [PIXEL_BITS-1:0]        mask  [mpr_pkg::CHANNELS];
    logic [TZW-1:0]               shift [mpr_pkg::CHANNELS];
    logic [PIXEL_BITS-1:0]        top   [mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] zero;
    logic                         front_rdy;

    logic                         vld_w  [NS+1];
    logic                         rdy_w  [NS+1];
    logic [NW-1:0]                rem_w  [NS+1][mpr_pkg::CHANNELS];
    logic [PIXEL_BITS-1:0]        den_w  [NS+1][mpr_pkg::CHANNELS];
    logic [mpr_pkg::OUT_W-1:0]    q_w    [NS+1][mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] zero_w [NS+1];

    mpr_cfg #(.PIXEL_BITS(PIXEL_BITS)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .mask      (mask),
        .shift     (shift),
        .top       (top),
        .zero      (zero)
    );

    // input transfer is held off while derived values settle
    assign s_tready = front_rdy && !busy;

    mpr_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_tvalid && !busy),
        .in_rdy   (front_rdy),
        .pixel    (s_tdata[PIXEL_BITS-1:0]),
        .mask     (mask),
        .shift    (shift),
        .top      (top),
        .zero     (zero),
        .out_vld  (vld_w[0]),
        .out_rdy  (rdy_w[0]),
        .rem      (rem_w[0]),
        .den      (den_w[0]),
        .zero_out (zero_w[0])
    );

    always_comb
    begin
        for (int c = 0; c < mpr_pkg::CHANNELS; c++)
        begin
            q_w[0][c] = '0;
        end
    end

    // divide chain, most significant quotient bit first
    for (genvar j = 0; j < NS; j++)
    begin : g_div
        mpr_div_stage #(.PIXEL_BITS(PIXEL_BITS), .STEP(NS - 1 - j)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld_w[j]),
            .in_rdy   (rdy_w[j]),
            .rem_in   (rem_w[j]),
            .den_in   (den_w[j]),
            .q_in     (q_w[j]),
            .zero_in  (zero_w[j]),
            .out_vld  (vld_w[j+1]),
            .out_rdy  (rdy_w[j+1]),
            .rem_out  (rem_w[j+1]),
            .den_out  (den_w[j+1]),
            .q_out    (q_w[j+1]),
            .zero_out (zero_w[j+1])
        );
    end

    assign rdy_w[NS] = m_tready;
    assign m_tvalid  = vld_w[NS];

    // zero mask gives zero for that channel
    always_comb
    begin
        for (int c = 0; c < mpr_pkg::CHANNELS; c++)
        begin
            m_tdata[c*mpr_pkg::OUT_W +: mpr_pkg::OUT_W] =
                zero_w[NS][c] ? '0 : q_w[NS][c];
        end
    end

endmodule

// ===== rtl/core/mpr_cfg.sv =====
// mask registers and per-channel derived values (shift, scale divisor)
// depends on mpr_pkg
module mpr_cfg #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF,
    localparam int TZW = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpr_pkg::MASK_W-1:0]     cfg_data,
    output logic                           busy,
    output logic [PIXEL_BITS-1:0]          mask   [mpr_pkg::CHANNELS],
    output logic [TZW-1:0]                 shift  [mpr_pkg::CHANNELS],
    output logic [PIXEL_BITS-1:0]          top    [mpr_pkg::CHANNELS],
    output logic [mpr_pkg::CHANNELS-1:0]   zero
);

    logic [mpr_pkg::MASK_W-1:0] mask_reg  [mpr_pkg::CHANNELS];
    logic [TZW-1:0]             tz_reg    [mpr_pkg::CHANNELS];
    logic [TZW-1:0]             tz_next   [mpr_pkg::CHANNELS];
    logic [PIXEL_BITS-1:0]      top_reg   [mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] zero_reg;
    logic [1:0]                 settle_reg;
    logic                       wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign busy      = (settle_reg != 2'd0);

    // register writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < mpr_pkg::CHANNELS; c++)
            begin
                mask_reg[c] <= '0;
            end
        end
        else if (wr)
        begin
            case (cfg_index)
                mpr_pkg::REG_RED:   mask_reg[mpr_pkg::CH_RED]   <= cfg_data;
                mpr_pkg::REG_GREEN: mask_reg[mpr_pkg::CH_GREEN] <= cfg_data;
                mpr_pkg::REG_BLUE:  mask_reg[mpr_pkg::CH_BLUE]  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // settle counter holds off input transfers after reset and after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= mpr_pkg::CFG_SETTLE;
        end
        else if (wr)
        begin
            settle_reg <= mpr_pkg::CFG_SETTLE;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // trailing-zero count of each cut mask
    always_comb
    begin
        for (int c = 0; c < mpr_pkg::CHANNELS; c++)
        begin
            tz_next[c] = '0;
            for (int i = PIXEL_BITS - 1; i >= 0; i--)
            begin
                if (mask_reg[c][i])
                begin
                    tz_next[c] = TZW'(i);
                end
            end
        end
    end

    // derived values, static while items flow
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < mpr_pkg::CHANNELS; c++)
        begin
            tz_reg[c]   <= tz_next[c];
            zero_reg[c] <= (mask_reg[c][PIXEL_BITS-1:0] == '0);
            top_reg[c]  <= mask_reg[c][PIXEL_BITS-1:0] >> tz_reg[c];
        end
    end

    always_comb
    begin
        for (int c = 0; c < mpr_pkg::CHANNELS; c++)
        begin
            mask[c]  = mask_reg[c][PIXEL_BITS-1:0];
            shift[c] = tz_reg[c];
            top[c]   = top_reg[c];
        end
    end
    assign zero = zero_reg;

endmodule

// ===== rtl/core/mpr_front.sv =====
// field extraction and times-255 product, two register stages
// depends on mpr_pkg
module mpr_front #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF,
    localparam int TZW = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1,
    localparam int NW  = PIXEL_BITS + mpr_pkg::OUT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    output logic                         in_rdy,
    input  logic [PIXEL_BITS-1:0]        pixel,
    input  logic [PIXEL_BITS-1:0]        mask   [mpr_pkg::CHANNELS],
    input  logic [TZW-1:0]               shift  [mpr_pkg::CHANNELS],
    input  logic [PIXEL_BITS-1:0]        top    [mpr_pkg::CHANNELS],
    input  logic [mpr_pkg::CHANNELS-1:0] zero,
    output logic                         out_vld,
    input  logic                         out_rdy,
    output logic [NW-1:0]                rem    [mpr_pkg::CHANNELS],
    output logic [PIXEL_BITS-1:0]        den    [mpr_pkg::CHANNELS],
    output logic [mpr_pkg::CHANNELS-1:0] zero_out
);

    logic                         a_vld_reg;
    logic [PIXEL_BITS-1:0]        a_field_reg [mpr_pkg::CHANNELS];
    logic [PIXEL_BITS-1:0]        a_den_reg   [mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] a_zero_reg;
    logic                         b_vld_reg;
    logic [NW-1:0]                b_rem_reg   [mpr_pkg::CHANNELS];
    logic [PIXEL_BITS-1:0]        b_den_reg   [mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] b_zero_reg;
    logic                         a_rdy;
    logic                         b_rdy;

    assign b_rdy  = !b_vld_reg || out_rdy;
    assign a_rdy  = !a_vld_reg || b_rdy;
    assign in_rdy = a_rdy;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_vld_reg <= in_vld;
            end
            if (b_rdy)
            begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    // stage a: mask and align each field
    always_ff @(posedge clk)
    begin
        if (a_rdy && in_vld)
        begin
            for (int c = 0; c < mpr_pkg::CHANNELS; c++)
            begin
                a_field_reg[c] <= (pixel & mask[c]) >> shift[c];
                a_den_reg[c]   <= top[c];
            end
            a_zero_reg <= zero;
        end
    end

    // stage b: field * 255 as (field << 8) - field
    always_ff @(posedge clk)
    begin
        if (b_rdy && a_vld_reg)
        begin
            for (int c = 0; c < mpr_pkg::CHANNELS; c++)
            begin
                b_rem_reg[c] <= (NW'(a_field_reg[c]) << mpr_pkg::OUT_W)
                              - NW'(a_field_reg[c]);
                b_den_reg[c] <= a_den_reg[c];
            end
            b_zero_reg <= a_zero_reg;
        end
    end

    assign out_vld  = b_vld_reg;
    assign rem      = b_rem_reg;
    assign den      = b_den_reg;
    assign zero_out = b_zero_reg;

endmodule

// ===== rtl/core/mpr_div_stage.sv =====
// one quotient bit of the restoring divide, for all three channels
// depends on mpr_pkg
module mpr_div_stage #(
    parameter int PIXEL_BITS = mpr_pkg::PIXEL_BITS_DEF,
    parameter int STEP       = 0,
    localparam int NW = PIXEL_BITS + mpr_pkg::OUT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    output logic                         in_rdy,
    input  logic [NW-1:0]                rem_in  [mpr_pkg::CHANNELS],
    input  logic [PIXEL_BITS-1:0]        den_in  [mpr_pkg::CHANNELS],
    input  logic [mpr_pkg::OUT_W-1:0]    q_in    [mpr_pkg::CHANNELS],
    input  logic [mpr_pkg::CHANNELS-1:0] zero_in,
    output logic                         out_vld,
    input  logic                         out_rdy,
    output logic [NW-1:0]                rem_out [mpr_pkg::CHANNELS],
    output logic [PIXEL_BITS-1:0]        den_out [mpr_pkg::CHANNELS],
    output logic [mpr_pkg::OUT_W-1:0]    q_out   [mpr_pkg::CHANNELS],
    output logic [mpr_pkg::CHANNELS-1:0] zero_out
);

    logic                         vld_reg;
    logic [NW-1:0]                rem_reg [mpr_pkg::CHANNELS];
    logic [PIXEL_BITS-1:0]        den_reg [mpr_pkg::CHANNELS];
    logic [mpr_pkg::OUT_W-1:0]    q_reg   [mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] zero_reg;
    logic [NW-1:0]                dsh     [mpr_pkg::CHANNELS];
    logic [mpr_pkg::CHANNELS-1:0] fits;

    assign in_rdy = !vld_reg || out_rdy;

    // trial subtract of the shifted divisor
    always_comb
    begin
        for (int c = 0; c < mpr_pkg::CHANNELS; c++)
        begin
            dsh[c]  = NW'(den_in[c]) << STEP;
            fits[c] = (rem_in[c] >= dsh[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_vld)
        begin
            for (int c = 0; c < mpr_pkg::CHANNELS; c++)
            begin
                rem_reg[c] <= fits[c] ? (rem_in[c] - dsh[c]) : rem_in[c];
                den_reg[c] <= den_in[c];
                q_reg[c]   <= q_in[c] | (mpr_pkg::OUT_W'(fits[c]) << STEP);
            end
            zero_reg <= zero_in;
        end
    end

    assign out_vld  = vld_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign q_out    = q_reg;
    assign zero_out = zero_reg;

endmodule

// ===== rtl/core/mpr_checker.sv =====
// port-level checks for the masked pixel to rgb888 core, bound to the top
// depends on mpr_pkg and masked_pixel_to_rgb888_core
module mpr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [3*mpr_pkg::OUT_W-1:0] m_tdata,
    input logic                        cfg_valid,
    input logic                        cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no input transfer right after a mask write
    a_cfg_hold1: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input taken one cycle after mask write");

    a_cfg_hold2: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> ##1 !s_tready)
        else $error("input taken two cycles after mask write");

    // configuration channel never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration ready dropped");

endmodule

bind masked_pixel_to_rgb888_core mpr_checker u_mpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
